>>> hw/rtl/key_press_long_press_detector_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key press / long press detector
// Concurrent check wrappers; empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef KEY_PRESS_LONG_PRESS_DETECTOR_UNIT_MACROS_SVH
`define KEY_PRESS_LONG_PRESS_DETECTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KPLP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kplp check failed");
// next-cycle implication
`define KPLP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kplp check failed");
`else
`define KPLP_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define KPLP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/kplp_pkg.sv
// ----------------------------------------------------------------------------
// kplp_pkg
// Shared types and constants of the key press / long press detector.
// ----------------------------------------------------------------------------
package kplp_pkg;

  localparam int KEY_LEVELS_W = 3;
  localparam int TIME_W       = 32;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 8;
  localparam int KEY_IDX_W    = 2;
  localparam int S_TDATA_W    = 40;  // 3 + 32 bits, padded to bytes
  localparam int M_TDATA_W    = 8;

  localparam logic [CFG_W-1:0] HOLDOFF_RST   = 16'd20;
  localparam logic [CFG_W-1:0] LONG_HOLD_RST = 16'd800;

  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD = 8'd1;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_PRESS = 2'd1,
    EV_LONG  = 2'd2
  } event_code_t;

  // what one key lane would do on this scan
  typedef struct packed {
    logic press;
    logic long_ev;
    logic rel_ev;
  } lane_req_t;

  // what the merge stage lets the lane commit
  typedef struct packed {
    logic ev;
    logic rel;
  } lane_grant_t;

endpackage

>>> hw/rtl/kplp_lane.sv
// ----------------------------------------------------------------------------
// kplp_lane
// Per-key state and event qualification for one key.
// ----------------------------------------------------------------------------
module kplp_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          level,
  input  logic [kplp_pkg::TIME_W-1:0]   now_ms,
  input  logic [kplp_pkg::CFG_W-1:0]    holdoff_ms,
  input  logic [kplp_pkg::CFG_W-1:0]    long_hold_ms,
  input  logic                          accept,
  input  kplp_pkg::lane_grant_t         grant,
  output kplp_pkg::lane_req_t           req
);
  import kplp_pkg::*;

  logic              stable_level;
  logic [TIME_W-1:0] event_time;
  logic              long_flag;
  logic [TIME_W-1:0] elapsed;

  // modulo 2^32 elapsed time
  assign elapsed = now_ms - event_time;

  always_comb begin
    req.press   = !level && stable_level &&
                  (elapsed >= {{(TIME_W-CFG_W){1'b0}}, holdoff_ms});
    req.long_ev = !level && !stable_level && !long_flag &&
                  (elapsed >= {{(TIME_W-CFG_W){1'b0}}, long_hold_ms});
    req.rel_ev  = level && !stable_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level <= 1'b1;
      event_time   <= '0;
      long_flag    <= 1'b0;
    end else if (accept) begin
      if (grant.ev) begin
        if (req.press) begin
          stable_level <= 1'b0;
          event_time   <= now_ms;
          long_flag    <= 1'b0;
        end else begin
          long_flag <= 1'b1;
        end
      end else if (grant.rel) begin
        stable_level <= 1'b1;
        event_time   <= now_ms;
      end
    end
  end

endmodule

>>> hw/rtl/kplp_merge.sv
// ----------------------------------------------------------------------------
// kplp_merge
// Priority pick over the key lanes: lowest key with an event wins; keys
// below it still commit their releases.
// ----------------------------------------------------------------------------
`include "key_press_long_press_detector_unit_macros.svh"

module kplp_merge #(
  parameter int NUM_KEYS = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  kplp_pkg::lane_req_t              req   [NUM_KEYS],
  output kplp_pkg::lane_grant_t            grant [NUM_KEYS],
  output logic [kplp_pkg::KEY_IDX_W-1:0]   key_index,
  output kplp_pkg::event_code_t            event_code
);
  import kplp_pkg::*;

  logic                seen;
  logic                is_press;
  logic [NUM_KEYS-1:0] ev_vec;
  logic [NUM_KEYS-1:0] rel_vec;

  always_comb begin
    seen      = 1'b0;
    is_press  = 1'b0;
    key_index = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      grant[k].ev  = (req[k].press || req[k].long_ev) && !seen;
      grant[k].rel = req[k].rel_ev && !seen;
      ev_vec[k]    = grant[k].ev;
      rel_vec[k]   = grant[k].rel;
      if (grant[k].ev) begin
        key_index = KEY_IDX_W'(k);
        is_press  = req[k].press;
      end
      seen = seen || req[k].press || req[k].long_ev;
    end
  end

  always_comb begin
    if (ev_vec == '0) begin
      event_code = EV_NONE;
    end else if (is_press) begin
      event_code = EV_PRESS;
    end else begin
      event_code = EV_LONG;
    end
  end

  `KPLP_ASSERT_NOW(a_one_winner, clk, rst, 1'b1, $onehot0(ev_vec))
  `KPLP_ASSERT_NOW(a_no_event_same_key, clk, rst, 1'b1, (ev_vec & rel_vec) == '0)
  `KPLP_ASSERT_NOW(a_none_no_index, clk, rst, event_code == EV_NONE, key_index == '0)

endmodule

>>> hw/rtl/key_press_long_press_detector_unit.sv
// ----------------------------------------------------------------------------
// key_press_long_press_detector_unit
// Key press and long-press detector: one lane per key, priority merge,
// registered result.
// ----------------------------------------------------------------------------
// Output: the result item of an accepted scan is loaded into the output register at the accept edge.
// Throughput: one scan per cycle unless back-pressured; per-key state updates
//   at accept, so lane compare plus priority pick over NUM_KEYS sets the path.
// Reset (rst, synchronous): all keys released, event times zero, long flags
//   clear, hold-off 20 ms, long hold 800 ms, output register empty.
`include "key_press_long_press_detector_unit_macros.svh"

module key_press_long_press_detector_unit #(
  parameter int NUM_KEYS = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  // scan input
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [kplp_pkg::S_TDATA_W-1:0]   s_tdata,   // [2:0] key_levels, [34:3] now_ms
  // result output
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [kplp_pkg::M_TDATA_W-1:0]   m_tdata,   // [1:0] key_index
  output logic [1:0]                       m_tuser,   // [1:0] event_code
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kplp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kplp_pkg::CFG_W-1:0]       cfg_data
);
  import kplp_pkg::*;

  logic [KEY_LEVELS_W-1:0] key_levels;
  logic [TIME_W-1:0]       now_ms;
  logic                    accept;
  logic [CFG_W-1:0]        holdoff_ms;
  logic [CFG_W-1:0]        long_hold_ms;
  lane_req_t               req   [NUM_KEYS];
  lane_grant_t             grant [NUM_KEYS];
  logic [KEY_IDX_W-1:0]    merge_index;
  event_code_t             merge_code;
  logic [KEY_IDX_W-1:0]    out_index;
  event_code_t             out_code;

  assign key_levels = s_tdata[KEY_LEVELS_W-1:0];
  assign now_ms     = s_tdata[KEY_LEVELS_W +: TIME_W];
  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff_ms   <= HOLDOFF_RST;
      long_hold_ms <= LONG_HOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HOLDOFF:   holdoff_ms   <= cfg_data;
        REG_LONG_HOLD: long_hold_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic level;
    // keys past the input field read pressed
    if (k < KEY_LEVELS_W) begin : g_in
      assign level = key_levels[k];
    end else begin : g_out
      assign level = 1'b0;
    end

    kplp_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .level        (level),
      .now_ms       (now_ms),
      .holdoff_ms   (holdoff_ms),
      .long_hold_ms (long_hold_ms),
      .accept       (accept),
      .grant        (grant[k]),
      .req          (req[k])
    );
  end

  kplp_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .grant      (grant),
    .key_index  (merge_index),
    .event_code (merge_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_index <= merge_index;
      out_code  <= merge_code;
    end
  end

  assign m_tdata = {{(M_TDATA_W-KEY_IDX_W){1'b0}}, out_index};
  assign m_tuser = out_code;

  `KPLP_ASSERT_NXT(a_accept_fills, clk, rst, accept, m_tvalid)
  `KPLP_ASSERT_NXT(a_code_loaded, clk, rst, accept, out_code == $past(merge_code))
  `KPLP_ASSERT_NXT(a_holdoff_write, clk, rst, cfg_valid && cfg_index == REG_HOLDOFF, holdoff_ms == $past(cfg_data))

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the key press / long press detector. Scans are streamed in
// with random gaps and random output stalls; a built-in tracker of per-key
// state predicts the event item for every accepted scan and compares it
// field by field with what the block returns. The run covers default,
// zero, maximum and random thresholds, timestamp wrap and back pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import kplp_pkg::*;

  localparam int NUM_KEYS = 3;
  // indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

  typedef struct packed {
    logic [KEY_IDX_W-1:0] key;
    event_code_t          code;
  } key_event_t;

  // Per-key state tracker and store of event items still to come
  class key_event_tracker;
    logic [CFG_W-1:0]  holdoff;
    logic [CFG_W-1:0]  long_hold;
    logic              level_q  [NUM_KEYS];
    logic [TIME_W-1:0] stamp    [NUM_KEYS];
    logic              long_done[NUM_KEYS];
    key_event_t        due_events[$];
    int unsigned       mismatches;

    function new();
      holdoff    = HOLDOFF_RST;
      long_hold  = LONG_HOLD_RST;
      mismatches = 0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        level_q[k]   = 1'b1;
        stamp[k]     = '0;
        long_done[k] = 1'b0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_HOLDOFF:   holdoff = val;
        REG_LONG_HOLD: long_hold = val;
        default: ;
      endcase
    endfunction

    function void note_scan(logic [KEY_LEVELS_W-1:0] levels, logic [TIME_W-1:0] now);
      key_event_t        ev;
      logic [TIME_W-1:0] elapsed;
      ev.key  = '0;
      ev.code = EV_NONE;
      for (int k = 0; k < NUM_KEYS; k++) begin
        elapsed = now - stamp[k];
        if (!levels[k] && level_q[k]) begin
          // lockout: press only once hold-off has passed since release
          if (elapsed >= {16'b0, holdoff}) begin
            level_q[k]   = 1'b0;
            stamp[k]     = now;
            long_done[k] = 1'b0;
            ev.key       = KEY_IDX_W'(k);
            ev.code      = EV_PRESS;
            break;
          end
        end else if (!levels[k]) begin
          if (!long_done[k] && elapsed >= {16'b0, long_hold}) begin
            long_done[k] = 1'b1;
            ev.key       = KEY_IDX_W'(k);
            ev.code      = EV_LONG;
            break;
          end
        end else if (!level_q[k]) begin
          level_q[k] = 1'b1;
          stamp[k]   = now;
        end
      end
      due_events.push_back(ev);
    endfunction

    function void check_result(logic [KEY_IDX_W-1:0] key, logic [1:0] code);
      key_event_t ev;
      if (due_events.size() == 0) begin
        $error("unexpected item: key_index %0d event_code %0d", key, code);
        mismatches++;
        return;
      end
      ev = due_events.pop_front();
      if (key !== ev.key) begin
        $error("key_index: expected %0d, actual %0d", ev.key, key);
        mismatches++;
      end
      if (code !== ev.code) begin
        $error("event_code: expected %0d, actual %0d", ev.code, code);
        mismatches++;
      end
    endfunction

    function int pending();
      return due_events.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [1:0]             m_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  key_event_tracker       tracker = new();
  logic [KEY_LEVELS_W-1:0] scan_levels;
  logic [TIME_W-1:0]      scan_now;
  bit                     src_steady;
  bit                     src_burst;
  bit                     sink_steady;
  int unsigned            sink_hold_len;

  key_press_long_press_detector_unit #(.NUM_KEYS(NUM_KEYS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_scan(input logic [KEY_LEVELS_W-1:0] levels,
                           input logic [TIME_W-1:0] now);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
    gap = (src_steady || src_burst) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, now, levels};
    do @(posedge clk); while (!s_tready);
    tracker.note_scan(levels, now);
    @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] holdoff, input logic [CFG_W-1:0] hold);
    write_reg(REG_HOLDOFF, holdoff);
    write_reg(REG_LONG_HOLD, hold);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Key levels mostly follow a held/released pattern with a rising clock;
  // now and then the levels or the time jump at random.
  task automatic run_scans(input int n, input int unsigned flip_odds);
    int unsigned       r;
    logic [TIME_W-1:0] step;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70)      step = $urandom_range(0, 40);
      else if (r < 90) step = $urandom_range(0, 1500);
      else if (r < 98) step = $urandom_range(0, 140000);
      else             step = $urandom;
      scan_now = scan_now + step;
      for (int k = 0; k < NUM_KEYS; k++)
        if ($urandom_range(0, flip_odds) == 0) scan_levels[k] = !scan_levels[k];
      if ($urandom_range(0, 49) == 0) scan_levels = KEY_LEVELS_W'($urandom_range(0, 7));
      send_scan(scan_levels, scan_now);
    end
  endtask

  // result side
  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
      if (sink_hold_len > 0) begin
        stall         = sink_hold_len;
        sink_hold_len = 0;
      end else begin
        stall = sink_steady ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tracker.check_result(m_tdata[KEY_IDX_W-1:0], m_tuser);
      @(negedge clk);
    end
  end

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    src_steady    = 1'b0;
    src_burst     = 1'b0;
    sink_steady   = 1'b0;
    sink_hold_len = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset thresholds (hold-off 20, long hold 800)
    send_scan(3'b111, 32'd0);
    send_scan(3'b110, 32'd5);            // first press lockout from time zero
    send_scan(3'b110, 32'd20);           // press key 0
    send_scan(3'b110, 32'd819);
    send_scan(3'b110, 32'd820);          // long press key 0
    send_scan(3'b110, 32'd5000);         // long press reported once
    send_scan(3'b000, 32'd5001);         // key 0 quiet, key 1 wins
    send_scan(3'b000, 32'd5002);         // key 2 press
    send_scan(3'b111, 32'd5003);         // all released
    send_scan(3'b110, 32'd5010);         // release-to-press lockout
    send_scan(3'b110, 32'd5023);
    send_scan(3'b011, 32'd5030);         // release of key 0 ahead of key 2 press
    send_scan(3'b111, 32'hFFFF_FFF0);
    send_scan(3'b011, 32'h0000_0010);    // elapsed across the wrap
    send_scan(3'b011, 32'h0000_0330);
    send_scan(3'b000, 32'hFFFF_FFFF);
    send_scan(3'b000, 32'h0000_0000);
    wait_results_done();

    // zero thresholds: press at once, long press on the next scan
    program_regs(16'd0, 16'd0);
    send_scan(3'b111, 32'd100);
    send_scan(3'b110, 32'd100);
    send_scan(3'b110, 32'd100);
    scan_levels = 3'b110;
    scan_now    = $urandom;
    run_scans(250, 4);
    wait_results_done();

    // maximum thresholds, starting just short of the wrap
    program_regs(16'hFFFF, 16'hFFFF);
    scan_now = 32'hFFFF_0000;
    run_scans(250, 12);
    wait_results_done();

    // writes to unmapped indexes must leave both registers alone
    write_reg(REG_UNMAPPED_LO, 16'($urandom));
    write_reg(REG_UNMAPPED_HI, 16'($urandom));
    cfg_valid <= 1'b0;
    send_scan(3'b111, scan_now);
    wait_results_done();

    // back pressure: output held off while items stream back to back
    program_regs(16'd10, 16'd300);
    src_burst     = 1'b1;
    sink_hold_len = 80;
    run_scans(40, 6);
    src_burst = 1'b0;
    run_scans(200, 8);
    wait_results_done();

    for (int p = 0; p < 4; p++) begin
      program_regs(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60)),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1200)));
      scan_now = $urandom;
      run_scans(215, $urandom_range(3, 30));
      wait_results_done();
    end

    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> key_press_long_press_detector_unit.f
+incdir+hw/rtl
hw/rtl/kplp_pkg.sv
hw/rtl/kplp_lane.sv
hw/rtl/kplp_merge.sv
hw/rtl/key_press_long_press_detector_unit.sv
verif/tb_top.sv
